// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/pcs_pkg.sv
// Package: widths and constants of the path candidate scorer.
package pcs_pkg;
  localparam int MaxCandidates = 64;
  localparam int MaxPoints = 1024;
  localparam logic [7:0] LethalReset = 8'd253;
  localparam logic [39:0] CostMax = 40'hFF_FFFF_FFFF;
  localparam logic [17:0] SumMax = 18'h3FFFF;
  localparam logic [10:0] CountMax = 11'd2047;
endpackage

// File: src/path_candidate_scorer_top.sv
// Path candidate scorer: per-point accumulation, turn measure and set winner.
// Each point: accumulation, then deltas; from the third point on a turn point also runs six
// serial products, two serial roots, the root product and the turn divide.
// A final point adds the mean divide, the cost sum and the output register.
// Throughput: one request at a time; in_stall is high until the sequencer is idle.
// Reset (rst_n low, synchronous): threshold 253, set and candidate state cleared.
module path_candidate_scorer_top #(
  parameter int MAX_CANDIDATES = pcs_pkg::MaxCandidates
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic               in_in_map,
  input  logic [7:0]         in_map_cost,
  input  logic signed [31:0] in_lateral_offset,
  input  logic               in_point_last,
  input  logic               in_set_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_cand_index,
  output logic               out_cand_valid,
  output logic [39:0]        out_cand_cost,
  output logic [16:0]        out_peak_turn,
  output logic               out_set_done,
  output logic [5:0]         out_best_index,
  output logic signed [31:0] out_best_offset
);
  // Saturation index for the candidate counter.
  localparam int CapI = ((MAX_CANDIDATES < 64) ? MAX_CANDIDATES : 64) - 1;
  localparam logic [5:0] CandCap = 6'(CapI);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;  // deltas and shift
  localparam logic [3:0] S_SQ    = 4'd2;  // squares and cross terms via serial multiply
  localparam logic [3:0] S_SQRT  = 4'd3;  // serial root, one bit pair per cycle
  localparam logic [3:0] S_MULD  = 4'd4;  // |d1|*|d2|
  localparam logic [3:0] S_DIV   = 4'd5;  // turn quotient
  localparam logic [3:0] S_MEAN  = 4'd6;  // mean cost divide
  localparam logic [3:0] S_SUM   = 4'd7;  // cost terms
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] st_r;
  logic [7:0] thr_r;

  // Candidate / set state.
  logic [31:0] last_off_r, best_off_r, cand_off_r;
  logic [39:0] win_cost_r;
  logic [5:0]  win_idx_r, cnt_r;
  logic [31:0] px_r [2];
  logic [31:0] py_r [2];
  logic [1:0]  seen_r;
  logic        lethal_r;
  logic [17:0] sum_r;
  logic [10:0] cnt_map_r;
  logic [16:0] peak_r;

  // Latched request.
  logic [31:0] qx_r, qy_r;
  logic        plast_r, slast_r, turn_r;

  // Shared datapath registers.
  logic signed [32:0] ax_r, ay_r, bx_r, by_r;
  logic [63:0] acc_r, op_a_r, op_b_r, n1_r, n2_r, rem_r;
  logic [63:0] root_r, bit_r, d_r, cr_r;
  logic [6:0]  step_r;
  logic [2:0]  phase_r;
  logic [16:0] q_r;
  logic [33:0] mean_r;

  // Output register.
  logic        ov_r;
  logic [5:0]  o_idx_r, o_bidx_r;
  logic        o_val_r, o_done_r;
  logic [39:0] o_cost_r;
  logic [16:0] o_turn_r;
  logic [31:0] o_boff_r;

  assign in_stall = (st_r != S_IDLE);
  wire acc_in = in_valid && !in_stall;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // Shift a signed delta's magnitude right, keep the sign.
  function automatic logic signed [32:0] shr(input logic signed [32:0] v,
                                             input logic [1:0] s);
    logic [32:0] m;
    m = mag33(v) >> s;
    shr = v[32] ? -$signed(m) : $signed(m);
  endfunction

  // Serial multiply: one add per cycle over 32 bits of op_b.
  wire [63:0] mul_step = op_b_r[0] ? acc_r + op_a_r : acc_r;

  // Root step.
  wire [63:0] rb = root_r + bit_r;
  wire        rge = rem_r >= rb;

  wire [39:0] abs_off = cand_off_r[31] ? 40'(-$signed(cand_off_r)) : 40'(cand_off_r);
  wire signed [33:0] dlt = 34'($signed(cand_off_r)) - 34'($signed(last_off_r));
  wire [33:0] abs_dlt = dlt[33] ? 34'(-dlt) : 34'(dlt);

  // Signs of the two cross products ax*by and ay*bx.
  wire cross_same = (ax_r[32] ^ by_r[32]) == (ay_r[32] ^ bx_r[32]);

  logic signed [32:0] dx0, dy0, dx1, dy1;
  logic [32:0] mx;
  logic [1:0]  sh;
  always_comb begin
    dx0 = 33'($signed(px_r[0])) - 33'($signed(px_r[1]));
    dy0 = 33'($signed(py_r[0])) - 33'($signed(py_r[1]));
    dx1 = 33'($signed(qx_r)) - 33'($signed(px_r[0]));
    dy1 = 33'($signed(qy_r)) - 33'($signed(py_r[0]));
    mx = mag33(dx0) | mag33(dy0) | mag33(dx1) | mag33(dy1);
    sh = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      thr_r <= pcs_pkg::LethalReset;
      last_off_r <= '0; best_off_r <= '0; win_cost_r <= pcs_pkg::CostMax;
      win_idx_r <= '0; cnt_r <= '0; cand_off_r <= '0;
      px_r[0] <= '0; px_r[1] <= '0; py_r[0] <= '0; py_r[1] <= '0;
      seen_r <= '0; lethal_r <= 1'b0; sum_r <= '0; cnt_map_r <= '0; peak_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      // S_OUT refills the slot itself when the held result leaves.
      if (ov_r && !out_stall && st_r != S_OUT) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (acc_in) begin
            qx_r <= in_pos_x; qy_r <= in_pos_y;
            plast_r <= in_point_last; slast_r <= in_set_last;
            turn_r <= (seen_r >= 2'd2);
            if (seen_r == 2'd0) cand_off_r <= in_lateral_offset;
            if (in_in_map) begin
              if (cnt_map_r < pcs_pkg::CountMax) cnt_map_r <= cnt_map_r + 11'd1;
              sum_r <= (19'(sum_r) + 19'(in_map_cost) > 19'(pcs_pkg::SumMax)) ?
                       pcs_pkg::SumMax : sum_r + 18'(in_map_cost);
              if (in_map_cost >= thr_r) lethal_r <= 1'b1;
            end
            st_r <= S_PREP;
          end
        end
        S_PREP: begin
          ax_r <= shr(dx0, sh); ay_r <= shr(dy0, sh);
          bx_r <= shr(dx1, sh); by_r <= shr(dy1, sh);
          px_r[1] <= px_r[0]; py_r[1] <= py_r[0];
          px_r[0] <= qx_r; py_r[0] <= qy_r;
          if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
          phase_r <= 3'd0; step_r <= '0;
          if (turn_r) st_r <= S_SQ;
          else st_r <= plast_r ? S_MEAN : S_IDLE;
          acc_r <= '0; rem_r <= {30'd0, sum_r, 16'd0}; q_r <= '0;
        end
        S_SQ: begin
          // Phases 0..3: ax^2, ay^2, bx^2, by^2; 4,5: ax*by, ay*bx.
          if (step_r == 7'd0) begin
            acc_r <= '0;
            case (phase_r)
              3'd0: begin op_a_r <= 64'(mag33(ax_r)); op_b_r <= 64'(mag33(ax_r)); end
              3'd1: begin op_a_r <= 64'(mag33(ay_r)); op_b_r <= 64'(mag33(ay_r)); end
              3'd2: begin op_a_r <= 64'(mag33(bx_r)); op_b_r <= 64'(mag33(bx_r)); end
              3'd3: begin op_a_r <= 64'(mag33(by_r)); op_b_r <= 64'(mag33(by_r)); end
              3'd4: begin op_a_r <= 64'(mag33(ax_r)); op_b_r <= 64'(mag33(by_r)); end
              default: begin op_a_r <= 64'(mag33(ay_r)); op_b_r <= 64'(mag33(bx_r)); end
            endcase
            step_r <= 7'd1;
          end else if (step_r <= 7'd32) begin
            acc_r <= mul_step; op_a_r <= op_a_r << 1; op_b_r <= op_b_r >> 1;
            step_r <= step_r + 7'd1;
          end else begin
            step_r <= '0;
            case (phase_r)
              3'd0: n1_r <= acc_r;
              3'd1: n1_r <= n1_r + acc_r;
              3'd2: n2_r <= acc_r;
              3'd3: n2_r <= n2_r + acc_r;
              3'd4: cr_r <= acc_r;
              // |cross|: difference of the magnitudes when the signs agree, else sum
              default: cr_r <= cross_same ?
                               ((cr_r >= acc_r) ? cr_r - acc_r : acc_r - cr_r) :
                               cr_r + acc_r;
            endcase
            if (phase_r == 3'd5) begin
              phase_r <= '0; st_r <= S_SQRT;
              rem_r <= n1_r; root_r <= '0; bit_r <= 64'd1 << 62;
            end else phase_r <= phase_r + 3'd1;
          end
        end
        S_SQRT: begin
          // phase 0: root of n1; phase 1: root of n2.
          if (bit_r == '0) begin
            if (phase_r == 3'd0) begin
              d_r <= root_r; phase_r <= 3'd1;
              rem_r <= n2_r; root_r <= '0; bit_r <= 64'd1 << 62;
            end else begin
              acc_r <= '0; op_a_r <= d_r; op_b_r <= root_r; step_r <= '0;
              st_r <= S_MULD;
            end
          end else begin
            if (rge) begin
              rem_r <= rem_r - rb; root_r <= (root_r >> 1) + bit_r;
            end else root_r <= root_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        S_MULD: begin
          if (step_r < 7'd32) begin
            acc_r <= mul_step; op_a_r <= op_a_r << 1; op_b_r <= op_b_r >> 1;
            step_r <= step_r + 7'd1;
          end else begin
            d_r <= acc_r; step_r <= '0; q_r <= '0; st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (d_r == '0) begin
            st_r <= plast_r ? S_MEAN : S_IDLE;
          end else if (step_r == 7'd0) begin
            if (cr_r >= d_r) begin
              if (peak_r < 17'd65536) peak_r <= 17'd65536;
              st_r <= plast_r ? S_MEAN : S_IDLE;
            end else step_r <= 7'd1;
          end else if (step_r <= 7'd16) begin
            if ({cr_r[62:0], 1'b0} >= d_r) begin
              cr_r <= {cr_r[62:0], 1'b0} - d_r; q_r <= {q_r[15:0], 1'b1};
            end else begin
              cr_r <= {cr_r[62:0], 1'b0}; q_r <= {q_r[15:0], 1'b0};
            end
            step_r <= step_r + 7'd1;
          end else begin
            if (q_r > peak_r) peak_r <= q_r;
            step_r <= '0;
            st_r <= plast_r ? S_MEAN : S_IDLE;
          end
          if (st_r == S_DIV && plast_r) begin
            rem_r <= {30'd0, sum_r, 16'd0}; mean_r <= '0;
          end
        end
        S_MEAN: begin
          // Restoring divide of sum<<16 by the in-map count, one bit per cycle.
          if (step_r == 7'd0) begin
            mean_r <= '0; cr_r <= '0; step_r <= 7'd1;
          end else if (step_r <= 7'd34) begin
            if ({cr_r[62:0], rem_r[33]} >= 64'(cnt_map_r)) begin
              cr_r <= {cr_r[62:0], rem_r[33]} - 64'(cnt_map_r);
              mean_r <= {mean_r[32:0], 1'b1};
            end else begin
              cr_r <= {cr_r[62:0], rem_r[33]};
              mean_r <= {mean_r[32:0], 1'b0};
            end
            rem_r <= {rem_r[62:0], 1'b0};
            step_r <= step_r + 7'd1;
          end else begin
            if (cnt_map_r == '0) mean_r <= '0;
            acc_r <= 64'(abs_dlt) * 64'd3;
            step_r <= '0; phase_r <= '0; st_r <= S_SUM;
          end
        end
        S_SUM: begin
          case (phase_r)
            3'd0: begin
              // 3*|delta| / 10: floor reciprocal lands at most two below
              cr_r <= (64'(acc_r[33:0]) * 64'd429496729) >> 32; phase_r <= 3'd1;
            end
            3'd1, 3'd2: begin
              if (acc_r - cr_r * 64'd10 >= 64'd10) cr_r <= cr_r + 64'd1;
              phase_r <= phase_r + 3'd1;
            end
            3'd3: begin
              acc_r <= 64'(mean_r) + 64'(abs_off >> 1) + 64'(peak_r) * 64'd10;
              phase_r <= 3'd4;
            end
            default: begin
              acc_r <= acc_r + cr_r; st_r <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!ov_r || !out_stall) begin
            logic [39:0] c;
            logic [5:0]  bi;
            logic [31:0] bo;
            logic [39:0] bc;
            c = lethal_r ? pcs_pkg::CostMax :
                ((acc_r > 64'(pcs_pkg::CostMax)) ? pcs_pkg::CostMax : acc_r[39:0]);
            bi = win_idx_r; bo = best_off_r; bc = win_cost_r;
            if (cnt_r == '0) begin bi = '0; bo = cand_off_r; end
            if (c < bc) begin bc = c; bi = cnt_r; bo = cand_off_r; end
            ov_r <= 1'b1;
            o_idx_r <= cnt_r; o_val_r <= !lethal_r; o_cost_r <= c;
            o_turn_r <= lethal_r ? '0 : peak_r;
            o_done_r <= slast_r;
            o_bidx_r <= slast_r ? bi : '0;
            o_boff_r <= slast_r ? bo : '0;
            if (slast_r) begin
              last_off_r <= bo; win_cost_r <= pcs_pkg::CostMax;
              win_idx_r <= '0; best_off_r <= '0; cnt_r <= '0;
            end else begin
              win_cost_r <= bc; win_idx_r <= bi; best_off_r <= bo;
              if (cnt_r < CandCap) cnt_r <= cnt_r + 6'd1;
            end
            px_r[0] <= '0; px_r[1] <= '0; py_r[0] <= '0; py_r[1] <= '0;
            seen_r <= '0; lethal_r <= 1'b0; sum_r <= '0; cnt_map_r <= '0;
            peak_r <= '0; cand_off_r <= '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_cand_index = o_idx_r;
  assign out_cand_valid = o_val_r;
  assign out_cand_cost = o_cost_r;
  assign out_peak_turn = o_turn_r;
  assign out_set_done = o_done_r;
  assign out_best_index = o_bidx_r;
  assign out_best_offset = o_boff_r;
endmodule

// File: src/pcs_checker.sv
// Port-level checker for the path candidate scorer, bound to the top level.
`include "assert_macros.svh"
module pcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_cand_valid,
  input logic [39:0] out_cand_cost,
  input logic [16:0] out_peak_turn,
  input logic        out_set_done,
  input logic [5:0]  out_best_index
);
  `CHK_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "no stall after request")
  `CHK_IMPLY(a_invalid_cost, clk, rst_n, out_valid && !out_cand_valid, out_cand_cost == 40'hFF_FFFF_FFFF && out_peak_turn == 17'd0, "invalid cost")
  `CHK_IMPLY(a_turn_range, clk, rst_n, out_valid, out_peak_turn <= 17'd65536, "turn range")
  `CHK_IMPLY(a_best_zero, clk, rst_n, out_valid && !out_set_done, out_best_index == 6'd0, "best index not zero")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
endmodule

bind path_candidate_scorer_top pcs_checker u_pcs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_cand_valid(out_cand_valid),
  .out_cand_cost(out_cand_cost), .out_peak_turn(out_peak_turn),
  .out_set_done(out_set_done), .out_best_index(out_best_index)
);

// File: test/path_candidate_scorer_tb.sv
// Self-checking testbench for the path candidate scorer.
module tb;

  // One scored candidate as it leaves the block.
  typedef struct packed {
    logic [5:0]  cand_index;
    logic        cand_valid;
    logic [39:0] cand_cost;
    logic [16:0] peak_turn;
    logic        set_done;
    logic [5:0]  best_index;
    logic [31:0] best_offset;
  } score_t;

  // Candidate-scoring predictor plus the queue of scores still owed by the block.
  class score_board;
    bit [7:0]         threshold;
    bit [31:0]        last_off;
    bit [39:0]        win_cost;
    bit [5:0]         win_idx;
    bit [31:0]        best_off;
    bit [5:0]         cand_cnt;
    bit signed [31:0] hist_x[2];
    bit signed [31:0] hist_y[2];
    int               pts_seen;
    bit               lethal;
    bit [17:0]        cost_acc;
    bit [10:0]        inmap_cnt;
    bit [16:0]        peak;
    bit [31:0]        cand_off;
    score_t           owed[$];
    int               mismatches;
    int               scored;
    int               sets_closed;

    function new();
      threshold = pcs_pkg::LethalReset;
      last_off = '0;
      clear_set();
      clear_cand();
    endfunction

    function void clear_set();
      win_cost = pcs_pkg::CostMax;
      win_idx = '0;
      best_off = '0;
      cand_cnt = '0;
    endfunction

    function void clear_cand();
      hist_x = '{0, 0};
      hist_y = '{0, 0};
      pts_seen = 0;
      lethal = 0;
      cost_acc = '0;
      inmap_cnt = '0;
      peak = '0;
      cand_off = '0;
    endfunction

    function bit [63:0] mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Bitwise integer square root, floor.
    function bit [63:0] int_root(bit [63:0] n);
      bit [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // |cross(d1,d2)| / (|d1||d2|) in Q1.16, saturated at 1.0.
    function bit [16:0] turn_of(longint x0, longint y0, longint x1, longint y1,
                                longint x2, longint y2);
      longint    dv[4];
      longint    c;
      bit [63:0] m, mg, cr, d;
      bit [16:0] q;
      int        s;
      dv[0] = x1 - x0;
      dv[1] = y1 - y0;
      dv[2] = x2 - x1;
      dv[3] = y2 - y1;
      m = 0;
      foreach (dv[i]) if (mag(dv[i]) > m) m = mag(dv[i]);
      s = 0;
      while ((m >> s) >= 64'h8000_0000) s++;
      foreach (dv[i]) begin
        mg = mag(dv[i]) >> s;
        dv[i] = (dv[i] < 0) ? -longint'(mg) : longint'(mg);
      end
      c = dv[0] * dv[3] - dv[1] * dv[2];
      cr = mag(c);
      d = int_root(dv[0] * dv[0] + dv[1] * dv[1]) * int_root(dv[2] * dv[2] + dv[3] * dv[3]);
      if (d == 0) return 0;
      if (cr >= d) return 17'd65536;
      q = 0;
      for (int i = 0; i < 16; i++) begin
        cr = cr << 1;
        q = q << 1;
        if (cr >= d) begin
          cr = cr - d;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    // Accepted point request: update candidate state, owe a score on the last point.
    function void note_request(bit signed [31:0] x, bit signed [31:0] y, bit inm,
                               bit [7:0] mc, bit signed [31:0] off, bit pl, bit sl);
      score_t      e;
      bit [16:0]   t;
      bit [63:0]   total;
      longint      o;
      if (pts_seen == 0) cand_off = off;
      if (inm) begin
        if (inmap_cnt != pcs_pkg::CountMax) inmap_cnt++;
        cost_acc = (int'(cost_acc) + mc > int'(pcs_pkg::SumMax)) ?
                   pcs_pkg::SumMax : cost_acc + mc;
        if (mc >= threshold) lethal = 1;
      end
      if (pts_seen >= 2) begin
        t = turn_of(hist_x[1], hist_y[1], hist_x[0], hist_y[0], x, y);
        if (t > peak) peak = t;
      end
      hist_x[1] = hist_x[0];
      hist_y[1] = hist_y[0];
      hist_x[0] = x;
      hist_y[0] = y;
      if (pts_seen < 3) pts_seen++;
      if (!pl) return;

      e = '0;
      total = pcs_pkg::CostMax;
      if (!lethal) begin
        o = longint'($signed(cand_off));
        total = (mag(o) >> 1) + 10 * peak + (mag(o - longint'($signed(last_off))) * 3) / 10;
        if (inmap_cnt != 0) total += (64'(cost_acc) << 16) / inmap_cnt;
        if (total > pcs_pkg::CostMax) total = pcs_pkg::CostMax;
        e.peak_turn = peak;
      end
      e.cand_index = cand_cnt;
      e.cand_valid = !lethal;
      e.cand_cost = total[39:0];
      // candidate 0 is the default winner
      if (cand_cnt == 0) begin
        win_idx = 0;
        best_off = cand_off;
      end
      if (total[39:0] < win_cost) begin
        win_cost = total[39:0];
        win_idx = cand_cnt;
        best_off = cand_off;
      end
      if (cand_cnt != 6'(pcs_pkg::MaxCandidates - 1)) cand_cnt++;
      if (sl) begin
        e.set_done = 1;
        e.best_index = win_idx;
        e.best_offset = best_off;
        last_off = best_off;
        clear_set();
      end
      clear_cand();
      owed.push_back(e);
    endfunction

    function void check(score_t got);
      score_t e;
      scored++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected score: %p", got);
        return;
      end
      e = owed.pop_front();
      if (got.set_done) sets_closed++;
      if (got.cand_index !== e.cand_index || got.cand_valid !== e.cand_valid ||
          got.cand_cost !== e.cand_cost || got.peak_turn !== e.peak_turn ||
          got.set_done !== e.set_done || got.best_index !== e.best_index ||
          got.best_offset !== e.best_offset) begin
        mismatches++;
        if (mismatches <= 10) $display("score mismatch\n  exp %p\n  got %p", e, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic               in_in_map;
  logic [7:0]         in_map_cost;
  logic signed [31:0] in_lateral_offset;
  logic               in_point_last;
  logic               in_set_last;
  logic               out_valid;
  logic               out_stall;
  logic [5:0]         out_cand_index;
  logic               out_cand_valid;
  logic [39:0]        out_cand_cost;
  logic [16:0]        out_peak_turn;
  logic               out_set_done;
  logic [5:0]         out_best_index;
  logic signed [31:0] out_best_offset;
  score_t             got;

  score_board sb;
  bit         idle_on;   // random gaps and stalls enabled
  bit         hold_out;  // receiver: one long hold-off requested
  int         points_sent;

  assign got = {out_cand_index, out_cand_valid, out_cand_cost, out_peak_turn,
                out_set_done, out_best_index, out_best_offset};

  path_candidate_scorer_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_in_map        (in_in_map),
    .in_map_cost      (in_map_cost),
    .in_lateral_offset(in_lateral_offset),
    .in_point_last    (in_point_last),
    .in_set_last      (in_set_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cand_index   (out_cand_index),
    .out_cand_valid   (out_cand_valid),
    .out_cand_cost    (out_cand_cost),
    .out_peak_turn    (out_peak_turn),
    .out_set_done     (out_set_done),
    .out_best_index   (out_best_index),
    .out_best_offset  (out_best_offset)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Score monitor: sample on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(got);
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        hold_out = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one point request at a falling edge, hold it until accepted.
  task automatic send_point(bit signed [31:0] x, bit signed [31:0] y, bit inm,
                            bit [7:0] mc, bit signed [31:0] off, bit pl, bit sl);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_in_map <= inm;
    in_map_cost <= mc;
    in_lateral_offset <= off;
    in_point_last <= pl;
    in_set_last <= sl;
    do @(posedge clk); while (in_stall);
    sb.note_request(x, y, inm, mc, off, pl, sl);
    points_sent++;
    @(negedge clk);
  endtask

  // Let every owed score come out, then allow a non-final point to finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_threshold(bit [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.threshold = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic bit [7:0] pick_cost();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 200));
  endfunction

  // One candidate of npts points with random content; zero-length segments
  // show up by repeating the previous point. Stray set_last on inner points.
  task automatic send_cand(int npts, bit close_set);
    bit [31:0] off, x, y;
    off = ($urandom_range(0, 3) == 0) ? pick_coord() : $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    x = pick_coord();
    y = pick_coord();
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(0, 5) != 0) begin
        x = (x + pick_coord() / ($urandom_range(0, 1) ? 1 : 64));
        y = (y + pick_coord() / ($urandom_range(0, 1) ? 1 : 64));
      end
      send_point(x, y, $urandom_range(0, 4) != 0, pick_cost(),
                 (i == 0) ? off : $urandom(), i == npts - 1,
                 (i == npts - 1) ? close_set : ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic random_sets(int nsets);
    int ncand;
    repeat (nsets) begin
      ncand = $urandom_range(1, 6);
      for (int c = 0; c < ncand; c++) send_cand($urandom_range(1, 7), c == ncand - 1);
    end
  endtask

  initial begin
    sb = new();
    idle_on = 0;
    hold_out = 0;
    points_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_in_map = 1'b0;
    in_map_cost = '0;
    in_lateral_offset = '0;
    in_point_last = 1'b0;
    in_set_last = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single off-map point closing a set (no in-map point, short).
    send_point(0, 0, 0, 8'd0, 32'h0001_0000, 1, 1);
    // Stray set_last on an inner point, extreme coordinates, two-point candidate.
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1, 8'd0, 32'h7FFF_FFFF, 0, 1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1, 8'd255, 32'h0, 1, 0);
    // Zero-length segment: repeated point.
    send_point(32'h0001_0000, 32'h0001_0000, 1, 8'd10, 32'h8000_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 1, 8'd20, 32'h0, 0, 0);
    send_point(32'h0002_0000, 32'h0003_0000, 1, 8'd252, 32'h0, 1, 0);
    // Right-angle turn, then a fold back from one extreme to the other
    // (segment deltas need the joint shift).
    send_point(32'h0, 32'h0, 1, 8'd5, 32'hFFFF_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0, 0, 8'd255, 32'h0, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 1, 8'd7, 32'h0, 0, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 1, 8'd0, 32'h0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 8'd0, 32'h0, 0, 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1, 8'd253, 32'h0, 1, 1);
    // All invalid: both candidates lethal, candidate 0 wins by default.
    send_point(32'h10, 32'h20, 1, 8'd253, 32'h0005_0000, 1, 0);
    send_point(32'h30, 32'h40, 1, 8'd255, 32'hFFFB_0000, 0, 0);
    send_point(32'h50, 32'h70, 1, 8'd1, 32'h0, 1, 1);
    // Two identical off-map one-point candidates form a set: a tie on cost.
    send_point(32'h0, 32'h0, 0, 8'd0, 32'h0, 1, 0);
    send_point(32'h0, 32'h0, 0, 8'd0, 32'h0, 1, 1);

    set_threshold(8'd0);
    idle_on = 1;
    random_sets(8);
    set_threshold(8'd255);
    random_sets(8);
    // Too many candidates: index saturates, later ones still compete.
    for (int c = 0; c < 67; c++) send_cand(1, c == 66);

    // Long hold-off on the result side while points keep coming.
    set_threshold(8'($urandom_range(1, 254)));
    hold_out = 1;
    for (int c = 0; c < 8; c++) send_cand(1, c == 7);
    random_sets(8);

    // Long candidate: the cost sum saturates.
    set_threshold(8'd255);
    idle_on = 0;
    for (int i = 0; i < 1040; i++)
      send_point(32'(i * 977), 32'(i * i), 1, 8'd254, 32'h0002_8000, i == 1039, 1);

    set_threshold(8'd128);
    idle_on = 1;
    random_sets(10);
    // Last part without idling on either side.
    idle_on = 0;
    random_sets(6);
    drain();

    $display("Sent %0d point requests; %0d scores checked, %0d sets closed, %0d mismatches.",
             points_sent, sb.scored, sb.sets_closed, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.owed.size() != 0) $display("%0d scores never arrived", sb.owed.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+src
src/pcs_pkg.sv
src/path_candidate_scorer_top.sv
src/pcs_checker.sv
test/path_candidate_scorer_tb.sv
